FILE: hdl/u2a_pkg.sv
// Package for the UTF-8 to ASCII transliterator: item types, character codes
// and the accent-stripping letter table. No dependencies.
`default_nettype none

package u2a_pkg;

    // Depth of the result queue in front of the master port.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Byte classes and masks used by the decoder.
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;

    // Code point range covered by the letter table.
    localparam logic [15:0] MAP_BASE = 16'h00C0;
    localparam logic [15:0] MAP_LAST = 16'h017F;

    // Code points that give two letters.
    localparam logic [15:0] CP_AE_UPPER = 16'h00C6;
    localparam logic [15:0] CP_AE_LOWER = 16'h00E6;
    localparam logic [15:0] CP_SHARP_S  = 16'h00DF;

    // ASCII codes.
    localparam logic [6:0] CH_QMARK = 7'h3F;
    localparam logic [6:0] CH_A     = 7'h41;
    localparam logic [6:0] CH_C     = 7'h43;
    localparam logic [6:0] CH_D     = 7'h44;
    localparam logic [6:0] CH_E     = 7'h45;
    localparam logic [6:0] CH_G     = 7'h47;
    localparam logic [6:0] CH_I     = 7'h49;
    localparam logic [6:0] CH_L     = 7'h4C;
    localparam logic [6:0] CH_N     = 7'h4E;
    localparam logic [6:0] CH_O     = 7'h4F;
    localparam logic [6:0] CH_R     = 7'h52;
    localparam logic [6:0] CH_S     = 7'h53;
    localparam logic [6:0] CH_T     = 7'h54;
    localparam logic [6:0] CH_U     = 7'h55;
    localparam logic [6:0] CH_Y     = 7'h59;
    localparam logic [6:0] CH_Z     = 7'h5A;
    localparam logic [6:0] CH_LOWER = 7'h20;

    // One result beat.
    typedef struct packed {
        logic       eos;
        logic       char_valid;
        logic [6:0] ch;
    } u2a_item_t;

    // Everything one input byte produces: up to two result beats.
    typedef struct packed {
        logic [1:0]      n;
        u2a_item_t [1:0] item;
    } u2a_res_t;

    // Letter for a code point between MAP_BASE and MAP_LAST; '?' where the
    // table has no entry.
    function automatic logic [6:0] latin_letter(input logic [15:0] cp);
        logic [6:0] up;
        logic       lower;
        up    = CH_QMARK;
        lower = 1'b0;
        if (cp[8] == 1'b0)
        begin
            // Latin-1 Supplement: lower case rows mirror the upper ones.
            lower = cp[5];
            case (cp[4:0]) inside
                [5'h00:5'h05]: up = CH_A;
                5'h07:         up = CH_C;
                [5'h08:5'h0B]: up = CH_E;
                [5'h0C:5'h0F]: up = CH_I;
                5'h10:         up = CH_D;
                5'h11:         up = CH_N;
                [5'h12:5'h16]: up = CH_O;
                5'h18:         up = CH_O;
                [5'h19:5'h1C]: up = CH_U;
                5'h1D:         up = CH_Y;
                5'h1F:         up = cp[5] ? CH_Y : CH_QMARK;
                default:       up = CH_QMARK;
            endcase
        end
        else
        begin
            // Latin Extended-A: upper/lower pairs, mostly upper on even codes.
            lower = cp[0];
            case (cp[7:0]) inside
                [8'h00:8'h05]: up = CH_A;
                [8'h06:8'h0D]: up = CH_C;
                [8'h0E:8'h11]: up = CH_D;
                [8'h12:8'h1B]: up = CH_E;
                [8'h1C:8'h23]: up = CH_G;
                [8'h30:8'h31]: up = CH_I;
                [8'h41:8'h42]:
                begin
                    up    = CH_L;
                    lower = ~cp[0];
                end
                [8'h43:8'h48]:
                begin
                    up    = CH_N;
                    lower = ~cp[0];
                end
                [8'h4C:8'h51]: up = CH_O;
                [8'h54:8'h59]: up = CH_R;
                [8'h5A:8'h61]: up = CH_S;
                [8'h62:8'h67]: up = CH_T;
                [8'h68:8'h73]: up = CH_U;
                [8'h79:8'h7E]:
                begin
                    up    = CH_Z;
                    lower = ~cp[0];
                end
                default:       up = CH_QMARK;
            endcase
        end
        if (up == CH_QMARK)
            return CH_QMARK;
        else
            return lower ? (up | CH_LOWER) : up;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/u2a_decode.sv
// UTF-8 sequence decoder: keeps the open-sequence state and turns one byte
// into zero, one or two result beats. Depends on u2a_pkg.
`default_nettype none

module u2a_decode
    import u2a_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,       // byte in b is consumed this cycle
    input  wire logic [7:0] b,
    input  wire logic       last,
    output u2a_res_t        res
);

    logic [1:0]  exp_reg, exp_next;       // tail bytes of the open sequence
    logic        col_reg, col_next;       // first tail byte of three taken
    logic [15:0] part_reg, part_next;     // code point bits gathered so far

    logic [15:0] cp;
    u2a_item_t   it0, it1;
    logic [1:0]  n;

    assign cp = part_reg | {10'd0, b[5:0]};

    // Decode the byte against the open sequence.
    always_comb
    begin
        exp_next  = exp_reg;
        col_next  = col_reg;
        part_next = part_reg;
        n         = 2'd0;
        it0       = '0;
        it1       = '0;
        if (exp_reg == 2'd0)
        begin
            if (b[7] == 1'b0)
            begin
                n      = 2'd1;
                it0.ch = b[6:0];
            end
            else if ((b & LEAD2_MASK) == LEAD2_CODE)
            begin
                if (!last)
                begin
                    exp_next  = 2'd1;
                    col_next  = 1'b0;
                    part_next = {5'd0, b[4:0], 6'd0};
                end
            end
            else if ((b & LEAD3_MASK) == LEAD3_CODE)
            begin
                if (!last)
                begin
                    exp_next  = 2'd2;
                    col_next  = 1'b0;
                    part_next = {b[3:0], 12'd0};
                end
            end
        end
        else if (exp_reg == 2'd1 || col_reg)
        begin
            // Sequence complete: map the code point.
            if (cp == CP_AE_UPPER)
            begin
                n      = 2'd2;
                it0.ch = CH_A;
                it1.ch = CH_E;
            end
            else if (cp == CP_AE_LOWER)
            begin
                n      = 2'd2;
                it0.ch = CH_A | CH_LOWER;
                it1.ch = CH_E | CH_LOWER;
            end
            else if (cp == CP_SHARP_S)
            begin
                n      = 2'd2;
                it0.ch = CH_S | CH_LOWER;
                it1.ch = CH_S | CH_LOWER;
            end
            else if (cp < MAP_BASE || cp > MAP_LAST)
            begin
                n      = 2'd1;
                it0.ch = CH_QMARK;
            end
            else
            begin
                n      = 2'd1;
                it0.ch = latin_letter(cp);
            end
            exp_next  = 2'd0;
            col_next  = 1'b0;
            part_next = '0;
        end
        else if (!last)
        begin
            col_next  = 1'b1;
            part_next = part_reg | {4'd0, b[5:0], 6'd0};
        end
        else
        begin
            // Lead dropped; the tail byte stands alone as the final byte.
            if (b[7] == 1'b0)
            begin
                n      = 2'd1;
                it0.ch = b[6:0];
            end
            exp_next  = 2'd0;
            col_next  = 1'b0;
            part_next = '0;
        end

        it0.char_valid = (n != 2'd0);
        it1.char_valid = (n == 2'd2);

        // The final byte closes any sequence and marks its last beat.
        if (last)
        begin
            exp_next  = 2'd0;
            col_next  = 1'b0;
            part_next = '0;
            if (n == 2'd2)
                it1.eos = 1'b1;
            else
            begin
                n       = 2'd1;
                it0.eos = 1'b1;
            end
        end

        res.n       = n;
        res.item[0] = it0;
        res.item[1] = it1;
    end

    // Sequence state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg  <= 2'd0;
            col_reg  <= 1'b0;
            part_reg <= '0;
        end
        else if (fire)
        begin
            exp_reg  <= exp_next;
            col_reg  <= col_next;
            part_reg <= part_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/utf8_to_ascii_transliterator.sv
// UTF-8 to ASCII transliterator, top level. Depends on u2a_pkg, u2a_decode.
// A byte passes through the input register, then the result queue, before
// its first result beat. Throughput: one byte per cycle while the queue
// has room for two beats; a code point that gives two letters (AE,
// ae, ss) sends two beats, limited by the single master port.
// Reset (rst_n, asynchronous, active low) empties the input register and the
// result queue and closes any open sequence.
`default_nettype none

module utf8_to_ascii_transliterator
    import u2a_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] in_byte
    input  wire logic       s_tlast,    // last_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,    // [6:0] out_char, [7] zero
    output logic            m_tuser,    // char_valid
    output logic            m_tlast     // end_of_string
);

    logic        stg_valid_reg;
    logic [7:0]  stg_byte_reg;
    logic        stg_last_reg;
    logic        advance;
    logic        pop;
    u2a_res_t    res;

    u2a_item_t   q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] rd_ptr_reg, wr_ptr_reg, wr_ptr1;
    logic [QCNT_W-1:0] cnt_reg;

    // The staged byte moves on when the queue has room for two beats,
    // counting the slot freed by a beat leaving in the same cycle.
    assign pop      = m_tvalid && m_tready;
    assign advance  = stg_valid_reg &&
                      ((cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2)) ||
                       (pop && (cnt_reg == QCNT_W'(QUEUE_DEPTH - 1))));
    assign s_tready = !stg_valid_reg || advance;
    assign wr_ptr1  = wr_ptr_reg + QPTR_W'(1);

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else if (s_tready)
            stg_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            stg_byte_reg <= s_tdata;
            stg_last_reg <= s_tlast;
        end
    end

    u2a_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .b     (stg_byte_reg),
        .last  (stg_last_reg),
        .res   (res)
    );

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (advance && res.n != 2'd0)
            q_reg[wr_ptr_reg] <= res.item[0];
        if (advance && res.n == 2'd2)
            q_reg[wr_ptr1] <= res.item[1];
    end

    // Result queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (advance)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(res.n);
            cnt_reg <= cnt_reg + (advance ? QCNT_W'(res.n) : QCNT_W'(0))
                               - QCNT_W'(pop);
        end
    end

    // Master beat.
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {1'b0, q_reg[rd_ptr_reg].ch};
    assign m_tuser  = q_reg[rd_ptr_reg].char_valid;
    assign m_tlast  = q_reg[rd_ptr_reg].eos;

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for utf8_to_ascii_transliterator: drives UTF-8 strings
// byte by byte and checks every result beat against a predictor in this file.
// Depends on u2a_pkg and the transliterator RTL.
`timescale 1ns / 1ps

module tb
    import u2a_pkg::*;
();

    localparam int CLK_PERIOD    = 8;
    localparam int ITEMS_TARGET  = 1950;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 20;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int MAX_SHOWN     = 10;
    localparam int TABLE_SIZE    = 192;

    // One letter per code point from MAP_BASE up to MAP_LAST; a dash means
    // that the code point has no plain letter.
    localparam logic [8*TABLE_SIZE-1:0] LATIN_LETTERS = {
        "AAAAAA-CEEEEIIII",
        "DNOOOOO-OUUUUY--",
        "aaaaaa-ceeeeiiii",
        "dnooooo-ouuuuy-y",
        "AaAaAaCcCcCcCcDd",
        "DdEeEeEeEeEeGgGg",
        "GgGg------------",
        "Ii--------------",
        "-LlNnNnNn---OoOo",
        "Oo--RrRrRrSsSsSs",
        "SsTtTtTtUuUuUuUu",
        "UuUu-----ZzZzZz-"
    };
    localparam logic [7:0] NO_LETTER = "-";

    typedef struct packed {
        logic       eos;
        logic       valid;
        logic [6:0] ch;
    } char_beat_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tready = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    // Decoder state of the predictor.
    logic [1:0]  seq_tails = 2'd0;
    logic [1:0]  seq_taken = 2'd0;
    logic [15:0] seq_cp    = 16'd0;

    char_beat_t  step_beats [2];
    int          step_count;
    char_beat_t  chars_due [$];
    logic [7:0]  string_bytes [$];

    int   error_count   = 0;
    int   bytes_sent    = 0;
    int   burst_left    = 0;
    logic sender_steady = 1'b0;
    logic hold_req      = 1'b0;

    utf8_to_ascii_transliterator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void report_error(input string msg);
        error_count++;
        if (error_count <= MAX_SHOWN)
            $display("%0t ns: %s", $time, msg);
    endfunction

    function automatic void emit_char(input logic [6:0] ch);
        if (step_count < 2)
        begin
            step_beats[step_count].ch    = ch;
            step_beats[step_count].valid = 1'b1;
            step_beats[step_count].eos   = 1'b0;
            step_count++;
        end
    endfunction

    function automatic void close_sequence();
        seq_tails = 2'd0;
        seq_taken = 2'd0;
        seq_cp    = 16'd0;
    endfunction

    // Adds one byte to the end of the string being built.
    function automatic void append_byte(input logic [7:0] v);
        string_bytes.insert(string_bytes.size(), v);
    endfunction

    // Works out the beats that one accepted byte causes and queues them.
    function automatic void predict_byte(input logic [7:0] b, input logic fin);
        logic [15:0] cp;
        logic [7:0]  letter;
        int          idx;
        int          k;
        step_count = 0;
        if (seq_tails == 2'd0)
        begin
            if (!b[7])
                emit_char(b[6:0]);
            else if ((b & LEAD2_MASK) == LEAD2_CODE)
            begin
                if (!fin)
                begin
                    seq_tails = 2'd1;
                    seq_taken = 2'd0;
                    seq_cp    = {5'd0, b[4:0], 6'd0};
                end
            end
            else if ((b & LEAD3_MASK) == LEAD3_CODE)
            begin
                if (!fin)
                begin
                    seq_tails = 2'd2;
                    seq_taken = 2'd0;
                    seq_cp    = {b[3:0], 12'd0};
                end
            end
        end
        else if (seq_tails == 2'd1 || seq_taken != 2'd0)
        begin
            // Sequence complete: map the code point to one or two letters.
            cp = seq_cp | {10'd0, b[5:0]};
            if (cp == CP_AE_UPPER)
            begin
                emit_char(CH_A);
                emit_char(CH_E);
            end
            else if (cp == CP_AE_LOWER)
            begin
                emit_char(CH_A | CH_LOWER);
                emit_char(CH_E | CH_LOWER);
            end
            else if (cp == CP_SHARP_S)
            begin
                emit_char(CH_S | CH_LOWER);
                emit_char(CH_S | CH_LOWER);
            end
            else if (cp < MAP_BASE || cp > MAP_LAST)
                emit_char(CH_QMARK);
            else
            begin
                idx    = int'(cp - MAP_BASE);
                letter = LATIN_LETTERS[8*(TABLE_SIZE-1-idx) +: 8];
                emit_char((letter == NO_LETTER) ? CH_QMARK : letter[6:0]);
            end
            close_sequence();
        end
        else if (!fin)
        begin
            seq_cp    = seq_cp | {4'd0, b[5:0], 6'd0};
            seq_taken = 2'd1;
        end
        else
        begin
            // The lead is dropped and the tail byte stands alone.
            if (!b[7])
                emit_char(b[6:0]);
            close_sequence();
        end

        // The final byte always ends with a marked beat, empty if need be.
        if (fin)
        begin
            close_sequence();
            if (step_count == 0)
            begin
                step_beats[0].ch    = 7'd0;
                step_beats[0].valid = 1'b0;
                step_beats[0].eos   = 1'b0;
                step_count          = 1;
            end
            step_beats[step_count-1].eos = 1'b1;
        end
        for (k = 0; k < step_count; k++)
            chars_due.insert(chars_due.size(), step_beats[k]);
    endfunction

    // Appends the UTF-8 encoding of a code point to the string being built.
    function automatic void add_code_point(input logic [15:0] cp);
        if (cp < 16'h0800)
        begin
            append_byte({3'b110, cp[10:6]});
            append_byte({2'b10, cp[5:0]});
        end
        else
        begin
            append_byte({4'b1110, cp[15:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
        end
    endfunction

    // Offers one byte, with random gaps between bursts, and waits for the beat.
    // Readiness is looked at on the falling edge before the sampling edge, once it has settled.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (!sender_steady && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        if (burst_left > 0)
            burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
        bytes_sent++;
        predict_byte(b, fin);
    endtask

    task automatic send_string();
        int k;
        for (k = 0; k < string_bytes.size(); k++)
            send_byte(string_bytes[k], k == string_bytes.size() - 1);
    endtask

    // Stops offering bytes until every expected beat has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (chars_due.size() != 0);
    endtask

    // Field extremes, every byte class and each corner of the decoder.
    task automatic test_corner_cases();
        // ASCII extremes, the second one ending a string.
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        // A stray continuation byte and a byte that leads no two- or three-byte form are dropped.
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        // Lowest and highest entries of the letter table.
        send_byte(8'hC3, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hC5, 1'b0);
        send_byte(8'hBF, 1'b0);
        // Code points that give two letters.
        send_byte(8'hC3, 1'b0);
        send_byte(8'h86, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA6, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h9F, 1'b0);
        // Three-byte sequence outside the table.
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b1);
        // Tail byte that is not a continuation byte is still taken.
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b0);
        // Lead byte as the final byte.
        send_byte(8'hC3, 1'b1);
        // Three-byte sequence cut after its first tail, ASCII and not.
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b1);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        // Stray final byte, then a sequence completed by the final byte.
        send_byte(8'h80, 1'b1);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b1);
    endtask

    // The receiver holds off while the sender keeps offering two-letter code
    // points, so the block fills up and stalls its input.
    task automatic test_stall_fill();
        int k;
        drain_results();
        sender_steady = 1'b1;
        hold_req      = 1'b1;
        string_bytes.delete();
        for (k = 0; k < 24; k++)
            add_code_point((k % 3 == 0) ? CP_AE_UPPER :
                           (k % 3 == 1) ? CP_SHARP_S : CP_AE_LOWER);
        send_string();
        sender_steady = 1'b0;
        drain_results();
    endtask

    // Random strings, mostly well formed, with malformed and cut sequences
    // and stray bytes mixed in.
    task automatic test_random_strings();
        logic [31:0] rnd;
        int          len;
        int          pick;
        int          k;
        int          strings_done;
        strings_done = 0;
        while (bytes_sent < ITEMS_TARGET)
        begin
            string_bytes.delete();
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            for (k = 0; k < len; k++)
            begin
                rnd  = $urandom;
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    append_byte({1'b0, rnd[6:0]});
                else if (pick < 70)
                    add_code_point(($urandom_range(0, 4) == 0) ?
                                   16'($urandom_range(16'h0080, 16'h07FF)) :
                                   16'($urandom_range(MAP_BASE, MAP_LAST)));
                else if (pick < 78)
                    add_code_point(16'($urandom_range(16'h0800, 16'hFFFF)));
                else if (pick < 89)
                begin
                    // Lead followed by arbitrary tail bytes.
                    if (rnd[31])
                    begin
                        append_byte({3'b110, rnd[4:0]});
                        append_byte(rnd[15:8]);
                    end
                    else
                    begin
                        append_byte({4'b1110, rnd[3:0]});
                        append_byte(rnd[15:8]);
                        append_byte(rnd[23:16]);
                    end
                end
                else
                    append_byte({1'b1, rnd[6:0]});
            end

            // Some strings end inside a sequence.
            if ($urandom_range(0, 5) == 0)
            begin
                rnd = $urandom;
                case (rnd[25:24])
                    2'd0:    append_byte({3'b110, rnd[4:0]});
                    2'd1:    append_byte({4'b1110, rnd[3:0]});
                    default:
                    begin
                        append_byte({4'b1110, rnd[3:0]});
                        append_byte(rnd[15:8]);
                    end
                endcase
            end

            send_string();
            strings_done++;
            if (strings_done % 25 == 0)
                drain_results();
        end
    endtask

    // Receiver readiness: runs of random styles, and a long hold-off on request.
    initial
    begin : ready_pattern
        int run_len;
        int style;
        int k;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
            end
            else
            begin
                style   = $urandom_range(0, 3);
                run_len = $urandom_range(4, 40);
                k       = 0;
                while (k < run_len && !hold_req)
                begin
                    case (style)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= ($urandom_range(0, 1) == 1);
                        2:       m_tready <= ($urandom_range(0, 3) == 0);
                        default: m_tready <= (k % 3 != 2);
                    endcase
                    @(posedge clk);
                    k++;
                end
            end
        end
    end

    // Compares each result beat with the oldest expected one.
    always @(posedge clk)
    begin : check_beats
        char_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (chars_due.size() == 0)
                report_error($sformatf("unexpected beat: tdata=%02h tuser=%b tlast=%b",
                                       m_tdata, m_tuser, m_tlast));
            else
            begin
                want = chars_due.pop_front();
                if (m_tdata !== {1'b0, want.ch} || m_tuser !== want.valid ||
                    m_tlast !== want.eos)
                    report_error($sformatf(
                        "expected tdata=%02h tuser=%b tlast=%b, got tdata=%02h tuser=%b tlast=%b",
                        {1'b0, want.ch}, want.valid, want.eos, m_tdata, m_tuser, m_tlast));
            end
        end
    end

    // Test sequence.
    initial
    begin : run_tests
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corner_cases();
        drain_results();
        test_stall_fill();
        test_random_strings();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (chars_due.size() != 0)
            report_error($sformatf("%0d expected beats never arrived", chars_due.size()));
        if (error_count == 0)
            $display("[utf8_to_ascii_transliterator] OK");
        else
            $display("[utf8_to_ascii_transliterator] ERROR");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("[utf8_to_ascii_transliterator] ERROR");
        $finish;
    end

endmodule

FILE: files.f
hdl/u2a_pkg.sv
hdl/u2a_decode.sv
hdl/utf8_to_ascii_transliterator.sv
bench/tb.sv
